/* rtl/core/assert_macros.svh */
// Assertion macros for the core RTL.
// No dependencies; switch off by defining ASSERT_OFF.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* rtl/core/trs_pkg.sv */
// Types and constants for the transform compose block.
// No dependencies.
package trs_pkg;
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_SOCKET = 2'd1;
  localparam logic [1:0] REQ_INST = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
  localparam logic signed [31:0] S16_ONE = 32'sh0001_0000;
  localparam logic signed [63:0] T_LIMIT = 64'sd160000000;
  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic [1:0] req_type;
    logic signed [31:0] trans_x, trans_y, trans_z;
    logic signed [31:0] rot_x, rot_y, rot_z, rot_w;
    logic signed [31:0] scale_x, scale_y, scale_z;
  } trs_in_t;

  typedef struct packed {
    logic signed [31:0] world_x, world_y, world_z;
    logic signed [31:0] quat_x, quat_y, quat_z, quat_w;
    logic signed [31:0] world_sx, world_sy, world_sz;
    logic in_range;
  } trs_out_t;
endpackage

/* rtl/core/trs_if.sv */
// Valid/ready channel carrying one beat of payload.
// The payload type is a parameter; no dependencies.
interface trs_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/trs_transform_compose.sv */
// Transform compose block: stored parent TRS, iterative shared multiplier.
// Depends on trs_pkg, trs_if and assert_macros.svh.
`include "assert_macros.svh"

// One item at a time. Load and unused codes only pass through S_FIN; socket and
// instance items run through one shared 32x32 multiplier and accumulator
// (53 product steps, the last four forming the squared quaternion length),
// a 32-step square-root recurrence and four restoring divides (a set-up step
// and 32 quotient bits each) run one after another on one divider. An instance
// item then passes S_FIN and S_OUT into the result register; a socket item
// updates the stored parent in S_FIN and gives no beat. A zero-length
// quaternion skips the divides and keeps its quaternion as it is.
// The result register holds the beat until taken; the block is not ready
// while an item is in progress or a result waits.
module trs_transform_compose import trs_pkg::*; (
  input logic clk,
  input logic rst,
  trs_if.sink in_ch,
  trs_if.source out_ch
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_MUL = 7'b0000010, S_SQRT = 7'b0000100,
    S_DIV = 7'b0001000, S_FIN = 7'b0010000, S_OUT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;
  state_t state;

  logic signed [31:0] pt [3];
  logic signed [31:0] pr [4];
  logic signed [31:0] ps [3];
  trs_in_t item;
  logic signed [31:0] a [4];
  logic signed [31:0] b [4];
  logic signed [31:0] qc [4];
  logic signed [31:0] mm [9];
  logic signed [31:0] vv [3];
  logic signed [31:0] ws [3];
  logic signed [31:0] wt [3];
  logic signed [31:0] wq [4];
  logic bad;
  logic [5:0] step;
  logic [3:0] sub;
  logic signed [95:0] acc;
  logic [63:0] sq_n, sq_r, sq_bit;
  logic [1:0] dch;
  logic [62:0] drem;
  logic [31:0] dquo;
  logic [5:0] dcnt;
  trs_out_t res;

  function automatic logic signed [31:0] clampu(input logic signed [31:0] v);
    if (v > Q30_ONE) return Q30_ONE;
    if (v < -Q30_ONE) return -Q30_ONE;
    return v;
  endfunction

  function automatic logic signed [95:0] rshift(input logic signed [95:0] v,
                                                input int s);
    logic signed [95:0] h;
    h = 96'sd1 <<< (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -((h - v) >>> s);
  endfunction

  function automatic logic sat_bad(input logic signed [95:0] v);
    return (v > 96'sh7FFF_FFFF) || (v < -96'sh8000_0000);
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [95:0] v);
    if (v > 96'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -96'sh8000_0000) return -32'sh8000_0000;
    return v[31:0];
  endfunction

  // product schedule: operand pair, sign, and term group end
  logic signed [31:0] op_a, op_b;
  logic neg, last;
  logic signed [63:0] prod;
  always_comb begin
    op_a = '0; op_b = '0; neg = 1'b0; last = 1'b0;
    case (step)
      6'd0: begin op_a = a[3]; op_b = b[0]; end
      6'd1: begin op_a = a[0]; op_b = b[3]; end
      6'd2: begin op_a = a[1]; op_b = b[2]; end
      6'd3: begin op_a = a[2]; op_b = b[1]; neg = 1'b1; last = 1'b1; end
      6'd4: begin op_a = a[3]; op_b = b[1]; end
      6'd5: begin op_a = a[0]; op_b = b[2]; neg = 1'b1; end
      6'd6: begin op_a = a[1]; op_b = b[3]; end
      6'd7: begin op_a = a[2]; op_b = b[0]; last = 1'b1; end
      6'd8: begin op_a = a[3]; op_b = b[2]; end
      6'd9: begin op_a = a[0]; op_b = b[1]; end
      6'd10: begin op_a = a[1]; op_b = b[0]; neg = 1'b1; end
      6'd11: begin op_a = a[2]; op_b = b[3]; last = 1'b1; end
      6'd12: begin op_a = a[3]; op_b = b[3]; end
      6'd13: begin op_a = a[0]; op_b = b[0]; neg = 1'b1; end
      6'd14: begin op_a = a[1]; op_b = b[1]; neg = 1'b1; end
      6'd15: begin op_a = a[2]; op_b = b[2]; neg = 1'b1; last = 1'b1; end
      6'd16: begin op_a = item.scale_x; op_b = ps[0]; last = 1'b1; end
      6'd17: begin op_a = item.scale_y; op_b = ps[1]; last = 1'b1; end
      6'd18: begin op_a = item.scale_z; op_b = ps[2]; last = 1'b1; end
      6'd19: begin op_a = a[1]; op_b = a[1]; neg = 1'b1; end
      6'd20: begin op_a = a[2]; op_b = a[2]; neg = 1'b1; last = 1'b1; end
      6'd21: begin op_a = a[0]; op_b = a[1]; end
      6'd22: begin op_a = a[3]; op_b = a[2]; neg = 1'b1; last = 1'b1; end
      6'd23: begin op_a = a[0]; op_b = a[2]; end
      6'd24: begin op_a = a[3]; op_b = a[1]; last = 1'b1; end
      6'd25: begin op_a = a[0]; op_b = a[1]; end
      6'd26: begin op_a = a[3]; op_b = a[2]; last = 1'b1; end
      6'd27: begin op_a = a[0]; op_b = a[0]; neg = 1'b1; end
      6'd28: begin op_a = a[2]; op_b = a[2]; neg = 1'b1; last = 1'b1; end
      6'd29: begin op_a = a[1]; op_b = a[2]; end
      6'd30: begin op_a = a[3]; op_b = a[0]; neg = 1'b1; last = 1'b1; end
      6'd31: begin op_a = a[0]; op_b = a[2]; end
      6'd32: begin op_a = a[3]; op_b = a[1]; neg = 1'b1; last = 1'b1; end
      6'd33: begin op_a = a[1]; op_b = a[2]; end
      6'd34: begin op_a = a[3]; op_b = a[0]; last = 1'b1; end
      6'd35: begin op_a = a[0]; op_b = a[0]; neg = 1'b1; end
      6'd36: begin op_a = a[1]; op_b = a[1]; neg = 1'b1; last = 1'b1; end
      6'd37: begin op_a = item.trans_x; op_b = ps[0]; last = 1'b1; end
      6'd38: begin op_a = item.trans_y; op_b = ps[1]; last = 1'b1; end
      6'd39: begin op_a = item.trans_z; op_b = ps[2]; last = 1'b1; end
      6'd40, 6'd43, 6'd46: begin op_a = mm[4'(step - 6'd40)]; op_b = vv[0]; end
      6'd41, 6'd44, 6'd47: begin op_a = mm[4'(step - 6'd40)]; op_b = vv[1]; end
      6'd42, 6'd45, 6'd48: begin
        op_a = mm[4'(step - 6'd40)]; op_b = vv[2]; last = 1'b1;
      end
      6'd49: begin op_a = qc[0]; op_b = qc[0]; end
      6'd50: begin op_a = qc[1]; op_b = qc[1]; end
      6'd51: begin op_a = qc[2]; op_b = qc[2]; end
      6'd52: begin op_a = qc[3]; op_b = qc[3]; last = 1'b1; end
      default: ;
    endcase
    prod = op_a * op_b;
  end

  logic signed [95:0] sum, rs, tsum;
  logic [4:0] mi;
  always_comb begin
    sum = neg ? acc - 96'(prod) : acc + 96'(prod);
    mi = 5'(step - 6'd19);
    if (step >= 6'd16 && step <= 6'd18) rs = rshift(sum, 16);
    else if (step >= 6'd37 && step <= 6'd39) rs = rshift(sum, 16);
    else if (step >= 6'd19 && step <= 6'd36) begin
      if (mi == 5'd1 || mi == 5'd9 || mi == 5'd17)
        rs = rshift((96'sd1 <<< 60) + 2 * sum, 30);
      else rs = rshift(2 * sum, 30);
    end else rs = rshift(sum, 30);
    tsum = rs + 96'(pt[sub[1:0]]);
  end

  logic [63:0] sq_t;
  logic [31:0] mag;
  always_comb begin
    sq_t = sq_r + sq_bit;
    mag = qc[dch][31] ? 32'(-qc[dch]) : 32'(qc[dch]);
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_DONE);
  assign out_ch.data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pt[0] <= '0; pt[1] <= '0; pt[2] <= '0;
      pr[0] <= '0; pr[1] <= '0; pr[2] <= '0; pr[3] <= Q30_ONE;
      ps[0] <= S16_ONE; ps[1] <= S16_ONE; ps[2] <= S16_ONE;
      step <= '0; sub <= '0; acc <= '0; bad <= 1'b0;
      dch <= '0; dcnt <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_ch.valid) begin
          item <= in_ch.data;
          if (in_ch.data.req_type == REQ_LOAD) begin
            pt[0] <= in_ch.data.trans_x; pt[1] <= in_ch.data.trans_y;
            pt[2] <= in_ch.data.trans_z;
            pr[0] <= in_ch.data.rot_x; pr[1] <= in_ch.data.rot_y;
            pr[2] <= in_ch.data.rot_z; pr[3] <= in_ch.data.rot_w;
            ps[0] <= in_ch.data.scale_x; ps[1] <= in_ch.data.scale_y;
            ps[2] <= in_ch.data.scale_z;
            state <= S_FIN;
          end else if (in_ch.data.req_type == REQ_SOCKET ||
                       in_ch.data.req_type == REQ_INST) begin
            for (int i = 0; i < 4; i++) a[i] <= clampu(pr[i]);
            b[0] <= clampu(in_ch.data.rot_x); b[1] <= clampu(in_ch.data.rot_y);
            b[2] <= clampu(in_ch.data.rot_z); b[3] <= clampu(in_ch.data.rot_w);
            bad <= (pr[0] != clampu(pr[0])) || (pr[1] != clampu(pr[1])) ||
                   (pr[2] != clampu(pr[2])) || (pr[3] != clampu(pr[3])) ||
                   (in_ch.data.rot_x != clampu(in_ch.data.rot_x)) ||
                   (in_ch.data.rot_y != clampu(in_ch.data.rot_y)) ||
                   (in_ch.data.rot_z != clampu(in_ch.data.rot_z)) ||
                   (in_ch.data.rot_w != clampu(in_ch.data.rot_w));
            step <= '0; sub <= '0; acc <= '0;
            state <= S_MUL;
          end else state <= S_FIN;
        end
        S_MUL: begin
          acc <= last ? '0 : sum;
          if (last) begin
            if (step <= 6'd15) begin
              qc[sub[1:0]] <= sat(rs);
              if (sat_bad(rs)) bad <= 1'b1;
            end else if (step <= 6'd18) begin
              ws[2'(sub - 4'd4)] <= sat(rs);
              if (sat_bad(rs)) bad <= 1'b1;
            end else if (step <= 6'd36) begin
              mm[sub - 4'd7] <= 32'(rs > 96'(Q30_ONE) ? 96'(Q30_ONE) :
                                   rs < -96'(Q30_ONE) ? -96'(Q30_ONE) : rs);
              if (rs > 96'(Q30_ONE) || rs < -96'(Q30_ONE)) bad <= 1'b1;
            end else if (step <= 6'd39) begin
              vv[2'(step - 6'd37)] <= sat(rs);
              if (sat_bad(rs)) bad <= 1'b1;
            end else if (step <= 6'd48) begin
              wt[sub[1:0]] <= sat(tsum);
              if (sat_bad(tsum) || tsum >= 96'(T_LIMIT) || tsum <= -96'(T_LIMIT))
                bad <= 1'b1;
            end
            sub <= (step == 6'd15 || step == 6'd18 || step == 6'd36 ||
                    step == 6'd39) ? ((step == 6'd15) ? 4'd4 :
                    (step == 6'd18) ? 4'd7 : 4'd0) : sub + 4'd1;
          end
          if (step == 6'd52) begin
            sq_n <= 64'(sum); sq_r <= '0; sq_bit <= 64'd1 << 62;
            dcnt <= '0;
            state <= S_SQRT;
          end
          step <= step + 6'd1;
        end
        S_SQRT: begin
          if (sq_n >= sq_t) begin
            sq_n <= sq_n - sq_t; sq_r <= (sq_r >> 1) + sq_bit;
          end else sq_r <= sq_r >> 1;
          sq_bit <= sq_bit >> 2;
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(SQRT_STEPS - 1)) begin
            dch <= '0; dcnt <= '0; state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide of (|c|<<30 + len/2) by len
          if (sq_r == '0) begin
            wq <= qc; state <= S_FIN;
          end else if (dcnt == '0) begin
            drem <= ({31'd0, mag} << 30) + 63'(sq_r >> 1);
            dquo <= '0; dcnt <= 6'd1;
          end else begin
            logic [63:0] tr;
            logic [62:0] dr;
            dr = drem;
            tr = {1'b0, dr} - (sq_r << (6'd32 - dcnt));
            if (!tr[63]) begin
              drem <= tr[62:0]; dquo <= dquo | (32'd1 << (6'd32 - dcnt));
            end
            if (dcnt == 6'd32) begin
              wq[dch] <= qc[dch][31] ? -$signed(tr[63] ? dquo :
                         (dquo | 32'd1)) : $signed(tr[63] ? dquo : (dquo | 32'd1));
              dcnt <= '0;
              if (dch == 2'd3) state <= S_FIN;
              dch <= dch + 2'd1;
            end else dcnt <= dcnt + 6'd1;
          end
        end
        S_FIN: begin
          if (item.req_type == REQ_SOCKET) begin
            pt <= wt; ps <= ws; pr <= wq;
            state <= S_IDLE;
          end else if (item.req_type == REQ_INST) state <= S_OUT;
          else state <= S_IDLE;
        end
        S_OUT: begin
          res <= '{wt[0], wt[1], wt[2], wq[0], wq[1], wq[2], wq[3],
                   ws[0], ws[1], ws[2], !bad};
          state <= S_DONE;
        end
        S_DONE: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_onehot, clk, rst, $onehot(state), "state not one-hot")
  `ASSERT_CLK(a_excl, clk, rst, !(in_ch.ready && out_ch.valid), "ready with result")
  `ASSERT_CLK(a_hold, clk, rst, out_ch.valid && !out_ch.ready |=> $stable(res),
              "result changed while held")
  `ASSERT_RST(a_rst, clk, rst |=> state == S_IDLE, "reset not idle")
endmodule
